FILE: rtl/fcg_pkg.sv
`default_nettype none
// -----------------------------------------------------------------------------
// fcg_pkg
// Types, constants and helper functions shared by the four-corner gradient
// generator and its serial divider.
// -----------------------------------------------------------------------------
package fcg_pkg;

   localparam int MAX_DIM     = 1024;
   localparam int DIM_W       = 10;
   localparam int CFG_DIM_W   = 11;
   localparam int COLOUR_W    = 24;
   localparam int CHAN_W      = 8;
   localparam int FRAC_BITS   = 16;
   localparam int ACC_W       = 48;
   localparam int STEP_W      = 25;
   localparam int ARGB_W      = 32;
   localparam int CSR_IDX_W   = 3;
   localparam int CSR_DATA_W  = 24;
   localparam int DIV_IDX_W   = 4;
   localparam int DIV_CNT_W   = $clog2(ACC_W);
   localparam int CHAN_IDX_W  = 2;
   localparam int NUM_CHAN    = 3;
   localparam int NUM_EDGE    = 6;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_IMAGE_WIDTH         = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_IMAGE_HEIGHT        = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_TOP_LEFT_COLOUR     = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_BOTTOM_LEFT_COLOUR  = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_TOP_RIGHT_COLOUR    = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_BOTTOM_RIGHT_COLOUR = 3'd5;

   // register reset values
   localparam logic [CFG_DIM_W-1:0] RESET_WIDTH        = 11'd320;
   localparam logic [CFG_DIM_W-1:0] RESET_HEIGHT       = 11'd240;
   localparam logic [COLOUR_W-1:0]  RESET_TOP_LEFT     = 24'hFF0000;
   localparam logic [COLOUR_W-1:0]  RESET_BOTTOM_LEFT  = 24'hFFFF00;
   localparam logic [COLOUR_W-1:0]  RESET_TOP_RIGHT    = 24'h0000FF;
   localparam logic [COLOUR_W-1:0]  RESET_BOTTOM_RIGHT = 24'h00FF00;

   // division slots: left edge steps, right edge steps, row steps
   localparam logic [DIV_IDX_W-1:0] DIV_LEFT_FIRST  = 4'd0;
   localparam logic [DIV_IDX_W-1:0] DIV_RIGHT_FIRST = 4'd3;
   localparam logic [DIV_IDX_W-1:0] DIV_ROW_FIRST   = 4'd6;
   localparam logic [DIV_IDX_W-1:0] DIV_ROW_LAST    = 4'd8;

   localparam logic [CHAN_W-1:0] ALPHA_OPAQUE = 8'hFF;

   typedef logic signed [ACC_W-1:0] acc_type;

   typedef struct packed {
      logic             start;
      acc_type          dividend;
      logic [DIM_W-1:0] divisor;
   } div_req_type;

   typedef struct packed {
      logic    done;
      acc_type quotient;
   } div_rsp_type;

   function automatic logic [CHAN_W-1:0] chan_of(input logic [COLOUR_W-1:0] rgb,
                                                 input logic [CHAN_IDX_W-1:0] c);
      logic [CHAN_W-1:0] ch;
      unique case (c)
         2'd0:    ch = rgb[23:16];
         2'd1:    ch = rgb[15:8];
         default: ch = rgb[7:0];
      endcase
      return ch;
   endfunction

   function automatic acc_type fixed_of(input logic [CHAN_W-1:0] ch);
      return acc_type'({{(ACC_W-CHAN_W-FRAC_BITS){1'b0}}, ch, {FRAC_BITS{1'b0}}});
   endfunction

   // clamped dimension minus one
   function automatic logic [DIM_W-1:0] dim_last(input logic [CFG_DIM_W-1:0] v);
      logic [CFG_DIM_W-1:0] m;
      if (v < CFG_DIM_W'(2)) begin
         m = CFG_DIM_W'(1);
      end else if (v > CFG_DIM_W'(MAX_DIM)) begin
         m = CFG_DIM_W'(MAX_DIM - 1);
      end else begin
         m = v - CFG_DIM_W'(1);
      end
      return m[DIM_W-1:0];
   endfunction

   function automatic logic [CHAN_W-1:0] sat_chan(input acc_type acc);
      logic [CHAN_W-1:0] ch;
      if (acc[ACC_W-1]) begin
         ch = '0;
      end else if (|acc[ACC_W-2:FRAC_BITS+CHAN_W]) begin
         ch = '1;
      end else begin
         ch = acc[FRAC_BITS+CHAN_W-1:FRAC_BITS];
      end
      return ch;
   endfunction

   // channel served by a division slot
   function automatic logic [CHAN_IDX_W-1:0] div_chan(input logic [DIV_IDX_W-1:0] idx);
      logic [DIV_IDX_W-1:0] c;
      if (idx < DIV_RIGHT_FIRST) begin
         c = idx - DIV_LEFT_FIRST;
      end else if (idx < DIV_ROW_FIRST) begin
         c = idx - DIV_RIGHT_FIRST;
      end else begin
         c = idx - DIV_ROW_FIRST;
      end
      return c[CHAN_IDX_W-1:0];
   endfunction

endpackage
`default_nettype wire

FILE: rtl/fcg_if.sv
`default_nettype none
// -----------------------------------------------------------------------------
// fcg_if
// Valid/ready channels of the gradient generator: request and pixel response.
// -----------------------------------------------------------------------------
interface fcg_req_if;
   logic valid;
   logic ready;
   logic restart;

   modport source (output valid, output restart, input ready);
   modport sink   (input valid, input restart, output ready);
endinterface

interface fcg_rsp_if;
   import fcg_pkg::*;
   logic              valid;
   logic              ready;
   logic [DIM_W-1:0]  pixel_x;
   logic [DIM_W-1:0]  pixel_y;
   logic [ARGB_W-1:0] pixel_argb;
   logic              row_end;
   logic              frame_end;

   modport source (output valid, output pixel_x, output pixel_y, output pixel_argb,
                   output row_end, output frame_end, input ready);
   modport sink   (input valid, input pixel_x, input pixel_y, input pixel_argb,
                   input row_end, input frame_end, output ready);
endinterface
`default_nettype wire

FILE: rtl/fcg_divider.sv
`default_nettype none
// -----------------------------------------------------------------------------
// fcg_divider
// Serial signed-by-unsigned divider, one quotient bit per cycle, quotient
// truncated toward zero. Done pulses for one cycle with the quotient valid.
// -----------------------------------------------------------------------------
module fcg_divider
   import fcg_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire div_req_type div_req,
   output div_rsp_type      div_rsp
);

   logic                 busy_ff,    busy_in;
   logic                 done_ff,    done_in;
   logic [DIV_CNT_W-1:0] count_ff,   count_in;
   logic                 neg_ff,     neg_in;
   logic [DIM_W-1:0]     rem_ff,     rem_in;
   logic [ACC_W-1:0]     quo_ff,     quo_in;
   logic [DIM_W-1:0]     divisor_ff, divisor_in;

   logic [DIM_W:0] shifted;
   logic [DIM_W:0] trial;

   always_comb begin
      shifted    = {rem_ff, quo_ff[ACC_W-1]};
      trial      = shifted - {1'b0, divisor_ff};
      busy_in    = busy_ff;
      done_in    = 1'b0;
      count_in   = count_ff;
      neg_in     = neg_ff;
      rem_in     = rem_ff;
      quo_in     = quo_ff;
      divisor_in = divisor_ff;
      if (div_req.start) begin
         busy_in    = 1'b1;
         count_in   = DIV_CNT_W'(ACC_W - 1);
         neg_in     = div_req.dividend[ACC_W-1];
         rem_in     = '0;
         quo_in     = div_req.dividend[ACC_W-1] ? ACC_W'(-div_req.dividend)
                                                : ACC_W'(div_req.dividend);
         divisor_in = div_req.divisor;
      end else if (busy_ff) begin
         // restore when the trial subtract goes negative
         if (trial[DIM_W]) begin
            rem_in = shifted[DIM_W-1:0];
            quo_in = {quo_ff[ACC_W-2:0], 1'b0};
         end else begin
            rem_in = trial[DIM_W-1:0];
            quo_in = {quo_ff[ACC_W-2:0], 1'b1};
         end
         count_in = count_ff - DIV_CNT_W'(1);
         if (count_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      count_ff   <= count_in;
      neg_ff     <= neg_in;
      rem_ff     <= rem_in;
      quo_ff     <= quo_in;
      divisor_ff <= divisor_in;
   end

   assign div_rsp.done     = done_ff;
   assign div_rsp.quotient = neg_ff ? -acc_type'(quo_ff) : acc_type'(quo_ff);

endmodule
`default_nettype wire

FILE: rtl/four_corner_gradient_generator_top.sv
`default_nettype none
// -----------------------------------------------------------------------------
// four_corner_gradient_generator_top
// Raster test-pattern source with a bilinear four-corner colour gradient.
// A pixel inside a row passes through ST_OUT, which holds until the output register
// is free and then registers it; the next transaction is taken back in ST_IDLE.
// A row start first runs 3 row-step divisions on the shared serial divider;
// frame start first adds the left and right edge-step divisions, one per channel.
// Throughput: one transaction at a time; the divider sets the row-start cost.
// Reset is synchronous: registers return to defaults and position to (0,0).
// -----------------------------------------------------------------------------
module four_corner_gradient_generator_top
   import fcg_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   fcg_req_if.sink                    req_ch,
   fcg_rsp_if.source                  rsp_ch,
   input  wire logic                  csr_we,
   input  wire logic [CSR_IDX_W-1:0]  csr_index,
   input  wire logic [CSR_DATA_W-1:0] csr_wdata
);

   localparam int ST_W = 3;
   localparam logic [ST_W-1:0] ST_IDLE = 3'd0;
   localparam logic [ST_W-1:0] ST_DIV  = 3'd1;
   localparam logic [ST_W-1:0] ST_WAIT = 3'd2;
   localparam logic [ST_W-1:0] ST_OUT  = 3'd3;

   // configuration
   logic [CFG_DIM_W-1:0] width_ff, height_ff;
   logic [COLOUR_W-1:0]  tl_ff, bl_ff, tr_ff, br_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= RESET_WIDTH;
         height_ff <= RESET_HEIGHT;
         tl_ff     <= RESET_TOP_LEFT;
         bl_ff     <= RESET_BOTTOM_LEFT;
         tr_ff     <= RESET_TOP_RIGHT;
         br_ff     <= RESET_BOTTOM_RIGHT;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_IMAGE_WIDTH:         width_ff  <= csr_wdata[CFG_DIM_W-1:0];
            CSR_IMAGE_HEIGHT:        height_ff <= csr_wdata[CFG_DIM_W-1:0];
            CSR_TOP_LEFT_COLOUR:     tl_ff     <= csr_wdata[COLOUR_W-1:0];
            CSR_BOTTOM_LEFT_COLOUR:  bl_ff     <= csr_wdata[COLOUR_W-1:0];
            CSR_TOP_RIGHT_COLOUR:    tr_ff     <= csr_wdata[COLOUR_W-1:0];
            CSR_BOTTOM_RIGHT_COLOUR: br_ff     <= csr_wdata[COLOUR_W-1:0];
            default: ;
         endcase
      end
   end

   logic [DIM_W-1:0] w_last, h_last;
   assign w_last = dim_last(width_ff);
   assign h_last = dim_last(height_ff);

   // sequencer and datapath state
   logic [ST_W-1:0]      state_ff;
   logic [DIV_IDX_W-1:0] div_idx_ff;
   logic [DIM_W-1:0]     col_ff, row_ff;
   acc_type              left_edge_ff  [NUM_CHAN];
   acc_type              right_edge_ff [NUM_CHAN];
   logic signed [STEP_W-1:0] edge_step_ff [NUM_EDGE];
   acc_type              row_acc_ff    [NUM_CHAN];
   acc_type              row_step_ff   [NUM_CHAN];

   logic              rsp_valid_ff;
   logic [DIM_W-1:0]  rsp_x_ff, rsp_y_ff;
   logic [ARGB_W-1:0] rsp_argb_ff;
   logic              rsp_row_end_ff, rsp_frame_end_ff;

   div_req_type div_req;
   div_rsp_type div_rsp;

   fcg_divider u_divider (
      .clock   (clock),
      .reset   (reset),
      .div_req (div_req),
      .div_rsp (div_rsp)
   );

   logic                  req_take;
   logic [DIM_W-1:0]      col_start, row_start;
   logic [CHAN_IDX_W-1:0] chan_sel;
   acc_type               div_from, div_to;
   logic                  out_free;
   logic                  rend, fend;

   assign req_ch.ready = (state_ff == ST_IDLE);
   assign req_take     = req_ch.valid && req_ch.ready;
   assign col_start    = req_ch.restart ? '0 : col_ff;
   assign row_start    = req_ch.restart ? '0 : row_ff;
   assign chan_sel     = div_chan(div_idx_ff);
   assign out_free     = !rsp_valid_ff || rsp_ch.ready;
   assign rend         = (col_ff >= w_last);
   assign fend         = rend && (row_ff >= h_last);

   // operands of the current division slot
   always_comb begin
      if (div_idx_ff < DIV_RIGHT_FIRST) begin
         div_from        = fixed_of(chan_of(tl_ff, chan_sel));
         div_to          = fixed_of(chan_of(bl_ff, chan_sel));
         div_req.divisor = h_last;
      end else if (div_idx_ff < DIV_ROW_FIRST) begin
         div_from        = fixed_of(chan_of(tr_ff, chan_sel));
         div_to          = fixed_of(chan_of(br_ff, chan_sel));
         div_req.divisor = h_last;
      end else begin
         div_from        = left_edge_ff[chan_sel];
         div_to          = right_edge_ff[chan_sel];
         div_req.divisor = w_last;
      end
      div_req.dividend = div_to - div_from;
      div_req.start    = (state_ff == ST_DIV);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         div_idx_ff   <= DIV_LEFT_FIRST;
         col_ff       <= '0;
         row_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         // a new pixel loaded in ST_OUT keeps the valid high
         if (rsp_valid_ff && rsp_ch.ready && state_ff != ST_OUT) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            ST_IDLE: begin
               if (req_take) begin
                  col_ff <= col_start;
                  row_ff <= row_start;
                  if (col_start == '0 && row_start == '0) begin
                     // frame start: load edges from the corners
                     for (int c = 0; c < NUM_CHAN; c++) begin
                        left_edge_ff[c]  <= fixed_of(chan_of(tl_ff, CHAN_IDX_W'(c)));
                        right_edge_ff[c] <= fixed_of(chan_of(tr_ff, CHAN_IDX_W'(c)));
                     end
                     div_idx_ff <= DIV_LEFT_FIRST;
                     state_ff   <= ST_DIV;
                  end else if (col_start == '0) begin
                     // row start: advance both edges one step
                     for (int c = 0; c < NUM_CHAN; c++) begin
                        left_edge_ff[c]  <= left_edge_ff[c] + acc_type'(edge_step_ff[c]);
                        right_edge_ff[c] <= right_edge_ff[c]
                                          + acc_type'(edge_step_ff[c + NUM_CHAN]);
                     end
                     div_idx_ff <= DIV_ROW_FIRST;
                     state_ff   <= ST_DIV;
                  end else begin
                     for (int c = 0; c < NUM_CHAN; c++) begin
                        row_acc_ff[c] <= row_acc_ff[c] + row_step_ff[c];
                     end
                     state_ff <= ST_OUT;
                  end
               end
            end
            ST_DIV: begin
               state_ff <= ST_WAIT;
            end
            ST_WAIT: begin
               if (div_rsp.done) begin
                  if (div_idx_ff < DIV_ROW_FIRST) begin
                     edge_step_ff[div_idx_ff[2:0]] <= div_rsp.quotient[STEP_W-1:0];
                  end else begin
                     row_step_ff[chan_sel] <= div_rsp.quotient;
                  end
                  if (div_idx_ff == DIV_ROW_LAST) begin
                     for (int c = 0; c < NUM_CHAN; c++) begin
                        row_acc_ff[c] <= left_edge_ff[c];
                     end
                     state_ff <= ST_OUT;
                  end else begin
                     div_idx_ff <= div_idx_ff + DIV_IDX_W'(1);
                     state_ff   <= ST_DIV;
                  end
               end
            end
            ST_OUT: begin
               // hold until the output register is free, then advance
               if (out_free) begin
                  rsp_valid_ff <= 1'b1;
                  if (rend) begin
                     col_ff <= '0;
                     row_ff <= fend ? '0 : row_ff + DIM_W'(1);
                  end else begin
                     col_ff <= col_ff + DIM_W'(1);
                  end
                  state_ff <= ST_IDLE;
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

   // output payload
   always_ff @(posedge clock) begin
      if (state_ff == ST_OUT && out_free) begin
         rsp_x_ff         <= col_ff;
         rsp_y_ff         <= row_ff;
         rsp_argb_ff      <= {ALPHA_OPAQUE, sat_chan(row_acc_ff[0]),
                              sat_chan(row_acc_ff[1]), sat_chan(row_acc_ff[2])};
         rsp_row_end_ff   <= rend;
         rsp_frame_end_ff <= fend;
      end
   end

   assign rsp_ch.valid      = rsp_valid_ff;
   assign rsp_ch.pixel_x    = rsp_x_ff;
   assign rsp_ch.pixel_y    = rsp_y_ff;
   assign rsp_ch.pixel_argb = rsp_argb_ff;
   assign rsp_ch.row_end    = rsp_row_end_ff;
   assign rsp_ch.frame_end  = rsp_frame_end_ff;

endmodule
`default_nettype wire

FILE: tb/sv/fcg_pixel_checker.sv
`default_nettype none
// -----------------------------------------------------------------------------
// fcg_pixel_checker
// Watches the tick, pixel and register-write ports of the four-corner gradient
// generator. It keeps its own raster position, edge and row accumulators, works
// out each pixel when its tick is accepted, and compares every pixel
// transaction field by field with the oldest pixel still due.
// -----------------------------------------------------------------------------
module fcg_pixel_checker
   import fcg_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   fcg_req_if                         req_ch,
   fcg_rsp_if                         rsp_ch,
   input  wire logic                  csr_we,
   input  wire logic [CSR_IDX_W-1:0]  csr_index,
   input  wire logic [CSR_DATA_W-1:0] csr_wdata,
   output int                         fail_count,
   output int                         pixels_due
);

   localparam int     REPORT_LIMIT = 10;
   localparam longint CHAN_MAX     = 255;

   typedef struct packed {
      logic [DIM_W-1:0]  x;
      logic [DIM_W-1:0]  y;
      logic [ARGB_W-1:0] argb;
      logic              row_end;
      logic              frame_end;
   } pixel_type;

   logic [CFG_DIM_W-1:0] width_cfg;
   logic [CFG_DIM_W-1:0] height_cfg;
   logic [COLOUR_W-1:0]  top_left_rgb;
   logic [COLOUR_W-1:0]  bottom_left_rgb;
   logic [COLOUR_W-1:0]  top_right_rgb;
   logic [COLOUR_W-1:0]  bottom_right_rgb;

   int     column_pos;
   int     row_pos;
   longint left_edge   [NUM_CHAN];
   longint right_edge  [NUM_CHAN];
   longint left_slope  [NUM_CHAN];
   longint right_slope [NUM_CHAN];
   longint row_colour  [NUM_CHAN];
   longint row_slope   [NUM_CHAN];

   pixel_type expected_pixels[$];
   int        mismatches = 0;

   function automatic int effective_dim(input logic [CFG_DIM_W-1:0] v);
      int d;
      d = int'(v);
      if (d < 2) begin
         d = 2;
      end else if (d > MAX_DIM) begin
         d = MAX_DIM;
      end
      return d;
   endfunction

   function automatic longint corner_fixed(input logic [COLOUR_W-1:0] rgb, input int c);
      logic [CHAN_W-1:0] ch;
      ch = rgb[COLOUR_W-1-CHAN_W*c -: CHAN_W];
      return longint'(ch) << FRAC_BITS;
   endfunction

   // signed division truncates toward zero
   function automatic longint gradient_slope(input longint from_v, input longint to_v,
                                             input int n);
      return (to_v - from_v) / longint'(n - 1);
   endfunction

   function automatic logic [CHAN_W-1:0] clamp_channel(input longint acc);
      longint whole;
      logic [CHAN_W-1:0] ch;
      whole = acc >>> FRAC_BITS;
      if (acc < 0) begin
         ch = '0;
      end else if (whole > CHAN_MAX) begin
         ch = '1;
      end else begin
         ch = whole[CHAN_W-1:0];
      end
      return ch;
   endfunction

   // Advance the raster by one tick and return the pixel it gives.
   function automatic pixel_type next_gradient_pixel(input logic restart);
      int w;
      int h;
      logic [CHAN_W-1:0] level [NUM_CHAN];
      pixel_type px;
      w = effective_dim(width_cfg);
      h = effective_dim(height_cfg);
      if (restart) begin
         column_pos = 0;
         row_pos    = 0;
      end
      for (int c = 0; c < NUM_CHAN; c++) begin
         if (column_pos == 0) begin
            if (row_pos == 0) begin
               // frame start: load edges from the corners
               left_edge[c]   = corner_fixed(top_left_rgb, c);
               right_edge[c]  = corner_fixed(top_right_rgb, c);
               left_slope[c]  = gradient_slope(left_edge[c],
                                               corner_fixed(bottom_left_rgb, c), h);
               right_slope[c] = gradient_slope(right_edge[c],
                                               corner_fixed(bottom_right_rgb, c), h);
            end else begin
               left_edge[c]  += left_slope[c];
               right_edge[c] += right_slope[c];
            end
            row_colour[c] = left_edge[c];
            row_slope[c]  = gradient_slope(left_edge[c], right_edge[c], w);
         end else begin
            row_colour[c] += row_slope[c];
         end
         level[c] = clamp_channel(row_colour[c]);
      end
      px.x         = column_pos[DIM_W-1:0];
      px.y         = row_pos[DIM_W-1:0];
      px.argb      = {ALPHA_OPAQUE, level[0], level[1], level[2]};
      px.row_end   = (column_pos >= w - 1);
      px.frame_end = px.row_end && (row_pos >= h - 1);
      if (px.row_end) begin
         column_pos = 0;
         row_pos    = px.frame_end ? 0 : row_pos + 1;
      end else begin
         column_pos++;
      end
      return px;
   endfunction

   function automatic void restore_defaults();
      width_cfg        = RESET_WIDTH;
      height_cfg       = RESET_HEIGHT;
      top_left_rgb     = RESET_TOP_LEFT;
      bottom_left_rgb  = RESET_BOTTOM_LEFT;
      top_right_rgb    = RESET_TOP_RIGHT;
      bottom_right_rgb = RESET_BOTTOM_RIGHT;
      column_pos       = 0;
      row_pos          = 0;
      for (int c = 0; c < NUM_CHAN; c++) begin
         left_edge[c]   = corner_fixed(top_left_rgb, c);
         right_edge[c]  = corner_fixed(top_right_rgb, c);
         left_slope[c]  = 0;
         right_slope[c] = 0;
         row_colour[c]  = left_edge[c];
         row_slope[c]   = 0;
      end
   endfunction

   always @(posedge clock) begin : watch_ports
      pixel_type want;
      pixel_type got;
      if (reset) begin
         restore_defaults();
         expected_pixels.delete();
      end else begin
         if (rsp_ch.valid && rsp_ch.ready) begin
            got.x         = rsp_ch.pixel_x;
            got.y         = rsp_ch.pixel_y;
            got.argb      = rsp_ch.pixel_argb;
            got.row_end   = rsp_ch.row_end;
            got.frame_end = rsp_ch.frame_end;
            if (expected_pixels.size() == 0) begin
               mismatches++;
               if (mismatches <= REPORT_LIMIT) begin
                  $display("unexpected pixel: x=%0d y=%0d argb=%08h row_end=%0b frame_end=%0b",
                           got.x, got.y, got.argb, got.row_end, got.frame_end);
               end
            end else begin
               want = expected_pixels.pop_front();
               if (got.x !== want.x || got.y !== want.y || got.argb !== want.argb ||
                   got.row_end !== want.row_end || got.frame_end !== want.frame_end) begin
                  mismatches++;
                  if (mismatches <= REPORT_LIMIT) begin
                     $display("expected x=%0d y=%0d argb=%08h row_end=%0b frame_end=%0b",
                              want.x, want.y, want.argb, want.row_end, want.frame_end);
                     $display("  actual x=%0d y=%0d argb=%08h row_end=%0b frame_end=%0b",
                              got.x, got.y, got.argb, got.row_end, got.frame_end);
                  end
               end
            end
         end
         if (req_ch.valid && req_ch.ready) begin
            expected_pixels.insert(expected_pixels.size(),
                                   next_gradient_pixel(req_ch.restart));
         end
         if (csr_we) begin
            case (csr_index)
               CSR_IMAGE_WIDTH:         width_cfg        = csr_wdata[CFG_DIM_W-1:0];
               CSR_IMAGE_HEIGHT:        height_cfg       = csr_wdata[CFG_DIM_W-1:0];
               CSR_TOP_LEFT_COLOUR:     top_left_rgb     = csr_wdata[COLOUR_W-1:0];
               CSR_BOTTOM_LEFT_COLOUR:  bottom_left_rgb  = csr_wdata[COLOUR_W-1:0];
               CSR_TOP_RIGHT_COLOUR:    top_right_rgb    = csr_wdata[COLOUR_W-1:0];
               CSR_BOTTOM_RIGHT_COLOUR: bottom_right_rgb = csr_wdata[COLOUR_W-1:0];
               default: ;  // drop writes to unused indexes
            endcase
         end
      end
      pixels_due = expected_pixels.size();
      fail_count = mismatches;
   end

endmodule
`default_nettype wire

FILE: tb/sv/testbench.sv
`default_nettype none
// -----------------------------------------------------------------------------
// testbench
// Regression for the four-corner gradient generator. A short directed run
// covers the reset pattern, clamped dimensions, frame wrap, mid-frame size
// changes and saturated channels; random phases follow with new register
// settings between them, bursty ticks with occasional restarts, and a pixel
// sink that stalls on shifting patterns and now and then holds off for long.
// -----------------------------------------------------------------------------
module testbench;
   import fcg_pkg::*;

   localparam int RANDOM_TICKS    = 1225;
   localparam int CYCLE_LIMIT     = 2_500_000;
   localparam int HOLD_OFF_CYCLES = 400;
   localparam int SETTLE_CYCLES   = 4;
   localparam int DRAIN_CYCLES    = 500;
   localparam int RESTART_PCT     = 2;

   localparam logic [CSR_IDX_W-1:0] CSR_SPARE_LOW  = 3'd6;
   localparam logic [CSR_IDX_W-1:0] CSR_SPARE_HIGH = 3'd7;

   logic                  clock     = 1'b0;
   logic                  reset     = 1'b1;
   logic                  csr_we    = 1'b0;
   logic [CSR_IDX_W-1:0]  csr_index = CSR_IMAGE_WIDTH;
   logic [CSR_DATA_W-1:0] csr_wdata = '0;

   int fail_count;
   int pixels_due;
   int cycle_count     = 0;
   int hold_off_asked  = 0;
   int hold_off_served = 0;
   int burst_left      = 0;

   fcg_req_if req_ch ();
   fcg_rsp_if rsp_ch ();

   four_corner_gradient_generator_top dut (
      .clock     (clock),
      .reset     (reset),
      .req_ch    (req_ch),
      .rsp_ch    (rsp_ch),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   fcg_pixel_checker pixel_checker (
      .clock      (clock),
      .reset      (reset),
      .req_ch     (req_ch),
      .rsp_ch     (rsp_ch),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .fail_count (fail_count),
      .pixels_due (pixels_due)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("four_corner_gradient_generator_top regression: fail");
         $finish;
      end
   end

   // Pixel sink: stall on a rotating pattern, or hold off for a long stretch on request.
   initial begin
      logic [15:0] stall_pattern;
      int pattern_left;
      int bit_pos;
      rsp_ch.ready  = 1'b0;
      stall_pattern = 16'hFFFF;
      pattern_left  = 0;
      bit_pos       = 0;
      forever begin
         @(negedge clock);
         if (hold_off_asked != hold_off_served) begin
            rsp_ch.ready <= 1'b0;
            repeat (HOLD_OFF_CYCLES) @(negedge clock);
            hold_off_served++;
         end else begin
            if (pattern_left == 0) begin
               if ($urandom_range(0, 3) == 0) begin
                  stall_pattern = 16'hFFFF;
               end else begin
                  stall_pattern = 16'($urandom) | 16'h0001;
               end
               pattern_left = $urandom_range(16, 64);
            end
            rsp_ch.ready <= stall_pattern[bit_pos];
            bit_pos = (bit_pos + 1) % 16;
            pattern_left--;
         end
      end
   end

   task automatic write_reg(input logic [CSR_IDX_W-1:0] index,
                            input logic [CSR_DATA_W-1:0] data);
      @(negedge clock);
      csr_we    <= 1'b1;
      csr_index <= index;
      csr_wdata <= data;
      @(negedge clock);
      csr_we    <= 1'b0;
   endtask

   task automatic program_frame(input logic [CFG_DIM_W-1:0] w, input logic [CFG_DIM_W-1:0] h,
                                input logic [COLOUR_W-1:0] tl, input logic [COLOUR_W-1:0] bl,
                                input logic [COLOUR_W-1:0] tr, input logic [COLOUR_W-1:0] br);
      write_reg(CSR_IMAGE_WIDTH, CSR_DATA_W'(w));
      write_reg(CSR_IMAGE_HEIGHT, CSR_DATA_W'(h));
      write_reg(CSR_TOP_LEFT_COLOUR, tl);
      write_reg(CSR_BOTTOM_LEFT_COLOUR, bl);
      write_reg(CSR_TOP_RIGHT_COLOUR, tr);
      write_reg(CSR_BOTTOM_RIGHT_COLOUR, br);
   endtask

   // Offer ticks in bursts; call and return at a falling edge.
   task automatic run_ticks(input int count, input logic first_restart, input int restart_pct);
      int gap;
      for (int i = 0; i < count; i++) begin
         if (burst_left == 0) begin
            burst_left = $urandom_range(1, 16);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0) begin
               req_ch.valid <= 1'b0;
               repeat (gap) @(negedge clock);
            end
         end
         burst_left--;
         req_ch.valid   <= 1'b1;
         req_ch.restart <= (i == 0) ? first_restart : ($urandom_range(0, 99) < restart_pct);
         do @(posedge clock); while (!req_ch.ready);
         @(negedge clock);
      end
   endtask

   task automatic wait_drained();
      req_ch.valid <= 1'b0;
      while (pixels_due != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   function automatic logic [CFG_DIM_W-1:0] pick_dim();
      logic [CFG_DIM_W-1:0] d;
      case ($urandom_range(0, 19))
         0:       d = CFG_DIM_W'($urandom_range(0, 1));
         1:       d = CFG_DIM_W'(MAX_DIM);
         2:       d = CFG_DIM_W'($urandom_range(MAX_DIM + 1, (1 << CFG_DIM_W) - 1));
         3:       d = CFG_DIM_W'($urandom_range(9, MAX_DIM));
         default: d = CFG_DIM_W'($urandom_range(2, 8));
      endcase
      return d;
   endfunction

   function automatic logic [COLOUR_W-1:0] pick_colour();
      logic [COLOUR_W-1:0] rgb;
      case ($urandom_range(0, 7))
         0:       rgb = '0;
         1:       rgb = '1;
         default: rgb = COLOUR_W'($urandom);
      endcase
      return rgb;
   endfunction

   initial begin
      int ticks_left;
      int n;
      logic [CSR_IDX_W-1:0] pick;
      req_ch.valid   = 1'b0;
      req_ch.restart = 1'b0;
      repeat (4) @(negedge clock);
      reset <= 1'b0;

      // reset pattern, 320x240 red/yellow/blue/green corners
      run_ticks(4, 1'b1, 0);
      wait_drained();

      // dimensions below two act as two; 2x2 frame wraps every four pixels
      program_frame('0, CFG_DIM_W'(1), 24'hFFFFFF, 24'h000000, 24'h000000, 24'hFFFFFF);
      write_reg(CSR_SPARE_LOW, 24'h000003);
      write_reg(CSR_SPARE_HIGH, 24'hFFFFFF);
      run_ticks(6, 1'b1, 0);
      wait_drained();

      // dimensions above the maximum clamp to it
      program_frame('1, CFG_DIM_W'(MAX_DIM), 24'h00FF80, 24'hFF00FF, 24'h123456, 24'hEDCBA9);
      run_ticks(3, 1'b1, 0);
      wait_drained();

      // 4x3 frame without a restart, stop partway into the third row
      program_frame(CFG_DIM_W'(4), CFG_DIM_W'(3), 24'hFF8000, 24'h0080FF,
                    24'h00FF00, 24'hFFFFFF);
      run_ticks(6, 1'b0, 0);
      wait_drained();

      // shrink the width and stretch the height mid-frame: the row ends at once and
      // the edges run past their corners into saturation
      write_reg(CSR_IMAGE_WIDTH, CSR_DATA_W'(2));
      write_reg(CSR_IMAGE_HEIGHT, CSR_DATA_W'(MAX_DIM));
      run_ticks(6, 1'b0, 0);
      wait_drained();

      ticks_left = RANDOM_TICKS;
      for (int phase = 0; ticks_left > 0; phase++) begin
         wait_drained();
         case ($urandom_range(0, 3))
            0, 1: begin
               program_frame(pick_dim(), pick_dim(), pick_colour(), pick_colour(),
                             pick_colour(), pick_colour());
            end
            2: begin
               // change a register or two and carry on mid-frame
               repeat ($urandom_range(1, 2)) begin
                  pick = CSR_IDX_W'($urandom_range(CSR_IMAGE_WIDTH, CSR_BOTTOM_RIGHT_COLOUR));
                  if (pick == CSR_IMAGE_WIDTH || pick == CSR_IMAGE_HEIGHT) begin
                     write_reg(pick, CSR_DATA_W'(pick_dim()));
                  end else begin
                     write_reg(pick, CSR_DATA_W'(pick_colour()));
                  end
               end
            end
            default: ;
         endcase
         if ($urandom_range(0, 7) == 0) begin
            write_reg($urandom_range(0, 1) ? CSR_SPARE_HIGH : CSR_SPARE_LOW,
                      CSR_DATA_W'($urandom));
         end
         if (phase % 7 == 3) begin
            hold_off_asked++;
         end
         n = $urandom_range(20, 80);
         if (n > ticks_left) begin
            n = ticks_left;
         end
         run_ticks(n, ($urandom_range(0, 2) == 0), RESTART_PCT);
         ticks_left -= n;
      end

      wait_drained();
      repeat (DRAIN_CYCLES) @(negedge clock);
      if (fail_count == 0 && pixels_due == 0) begin
         $display("four_corner_gradient_generator_top regression: pass");
      end else begin
         $display("four_corner_gradient_generator_top regression: fail");
      end
      $finish;
   end

endmodule
`default_nettype wire

FILE: filelist.f
rtl/fcg_pkg.sv
rtl/fcg_if.sv
rtl/fcg_divider.sv
rtl/four_corner_gradient_generator_top.sv
tb/sv/fcg_pixel_checker.sv
tb/sv/testbench.sv
